[sv/ptrc_pkg.sv]
// ----------------------------------------------------------------------------
// ptrc_pkg
// Shared types, key codes and constant tables for the paced tape reader.
// ----------------------------------------------------------------------------
package ptrc_pkg;

    // one incoming item: timer tick or host key, plus sampled line state
    typedef struct packed {
        logic       command;
        logic [7:0] key_byte;
        logic       reader_ready;
        logic [7:0] reader_data;
        logic       dtr;
        logic       rts;
        logic       link_ready;
    } in_item_t;

    // one emitted byte
    typedef struct packed {
        logic [7:0] out_byte;
        logic       reader_strobe;
        logic       last_in_run;
    } out_item_t;

    // one granted capture handed to the serializer
    typedef struct packed {
        logic [7:0] data;
        logic       hex;
    } capture_t;

    localparam int unsigned RATE_W = 16;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_KEY  = 1'b1;

    localparam logic [7:0] KEY_RAW    = 8'h62; // 'b'
    localparam logic [7:0] KEY_HEX    = 8'h68; // 'h'
    localparam logic [7:0] KEY_ONCE   = 8'h30; // '0'
    localparam logic [7:0] KEY_FIRST  = 8'h31; // '1'
    localparam logic [7:0] KEY_LAST   = 8'h39; // '9'
    localparam logic [7:0] KEY_SLOWER = 8'h2D; // '-'
    localparam logic [7:0] KEY_FASTER = 8'h2B; // '+'

    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_LOWA  = 8'h61;

    localparam logic [RATE_W-1:0] FASTEST_LIMIT = 16'd65500;

    // preset limits for keys '1' to '9'
    function automatic logic [RATE_W-1:0] speed_limit(input logic [3:0] sel);
        logic [RATE_W-1:0] v;
        begin
            case (sel)
                4'd0:    v = 16'd15000;
                4'd1:    v = 16'd7500;
                4'd2:    v = 16'd3750;
                4'd3:    v = 16'd1500;
                4'd4:    v = 16'd750;
                4'd5:    v = 16'd600;
                4'd6:    v = 16'd400;
                4'd7:    v = 16'd300;
                4'd8:    v = 16'd16;
                default: v = 16'd15000;
            endcase
            return v;
        end
    endfunction

    // lowercase ascii hex digit
    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        begin
            if (n < 4'd10)
                return CHAR_ZERO + {4'd0, n};
            else
                return CHAR_LOWA + {4'd0, n} - 8'd10;
        end
    endfunction

endpackage

[sv/paced_tape_reader_capture.sv]
// ----------------------------------------------------------------------------
// paced_tape_reader_capture
// Paces a parallel paper-tape reader from timer ticks and host key bytes.
// ----------------------------------------------------------------------------
// Ticks and keys are taken one per cycle, while cmd_ready is high, into an
// input register; the rate limit, tick count and raw/hex mode are updated as
// an item leaves it. A granted capture is handed to the output serializer,
// whose register drives the result channel. A raw capture is one byte and a
// hex capture (two digits, CR, LF) four; back-to-back captures share the
// single output port, and the serializer takes the next capture as the last
// byte of the current one is taken. While a capture waits for the serializer
// the input register holds it and cmd_ready drops. Items that cause no
// capture never wait on the serializer. reader_strobe marks the first byte
// of each capture and last_in_run its final byte. An item with link_ready
// low has no effect.
module paced_tape_reader_capture (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  ptrc_pkg::in_item_t  cmd,
    output logic                res_valid,
    input  logic                res_ready,
    output ptrc_pkg::out_item_t res
);

    // capture request between decode and serializer
    logic               cap_valid;
    logic               cap_ready;
    ptrc_pkg::capture_t cap;

    // pacing state, key decode, input register
    ptrc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .cap_valid (cap_valid),
        .cap_ready (cap_ready),
        .cap       (cap)
    );

    // byte sequencing for one capture
    ptrc_ser u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cap_valid (cap_valid),
        .cap_ready (cap_ready),
        .cap       (cap),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // input stalls only behind a capture the serializer cannot yet take
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_ready |-> (cap_valid && !cap_ready))
        else $error("input stalled without a blocked capture");

    // a blocked capture request keeps its byte
    a_cap_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (cap_valid && !cap_ready) |=> (cap_valid && $stable(cap.data)))
        else $error("capture request dropped or changed while blocked");

    // a hex run continues after a middle byte is taken
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready && !res.last_in_run) |=>
            (res_valid && !res.reader_strobe))
        else $error("hex run broken before its final byte");

endmodule

[sv/ptrc_ctrl.sv]
// ----------------------------------------------------------------------------
// ptrc_ctrl
// Input register, pacing state and key decode; issues capture requests.
// ----------------------------------------------------------------------------
module ptrc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  ptrc_pkg::in_item_t  cmd,
    output logic                cap_valid,
    input  logic                cap_ready,
    output ptrc_pkg::capture_t  cap
);

    logic                        s1_valid_reg;
    ptrc_pkg::in_item_t          s1_item_reg;
    logic [ptrc_pkg::RATE_W-1:0] rate_reg;
    logic [ptrc_pkg::RATE_W-1:0] rate_next;
    logic [ptrc_pkg::RATE_W-1:0] count_reg;
    logic [ptrc_pkg::RATE_W-1:0] count_next;
    logic                        hex_reg;
    logic                        hex_next;

    logic [ptrc_pkg::RATE_W-1:0] rate_eff;
    logic [ptrc_pkg::RATE_W-1:0] count_inc;
    logic [ptrc_pkg::RATE_W-1:0] rate_x;
    logic [7:0]                  key_off;
    logic                        try_cap;
    logic                        cap_ok;
    logic                        advance;

    always_comb
    begin
        rate_eff   = s1_item_reg.dtr ? rate_reg : '0;
        count_inc  = count_reg + 1'b1;
        key_off    = s1_item_reg.key_byte - ptrc_pkg::KEY_FIRST;
        rate_x     = '0;
        rate_next  = rate_reg;
        count_next = count_reg;
        hex_next   = hex_reg;
        try_cap    = 1'b0;

        if (s1_item_reg.link_ready)
        begin
            rate_next = rate_eff;
            if (s1_item_reg.command == ptrc_pkg::CMD_TICK)
            begin
                if (rate_eff != '0 && count_inc > rate_eff)
                begin
                    count_next = '0;
                    try_cap    = 1'b1;
                end
                else
                begin
                    count_next = count_inc;
                end
            end
            else if (s1_item_reg.key_byte inside
                     {[ptrc_pkg::KEY_FIRST:ptrc_pkg::KEY_LAST]})
            begin
                rate_next = ptrc_pkg::speed_limit(key_off[3:0]);
            end
            else
            begin
                case (s1_item_reg.key_byte)
                    ptrc_pkg::KEY_RAW:  hex_next = 1'b0;
                    ptrc_pkg::KEY_HEX:  hex_next = 1'b1;
                    ptrc_pkg::KEY_ONCE:
                    begin
                        rate_next = '0;
                        try_cap   = 1'b1;
                    end
                    ptrc_pkg::KEY_SLOWER:
                    begin
                        rate_x    = rate_eff + (rate_eff >> 4);
                        rate_next = (rate_x > rate_eff) ? rate_x : '0;
                    end
                    ptrc_pkg::KEY_FASTER:
                    begin
                        rate_x = rate_eff - (rate_eff >> 4);
                        if (rate_eff == '0)
                            rate_next = ptrc_pkg::FASTEST_LIMIT;
                        else if (rate_x < rate_eff)
                            rate_next = rate_x;
                        else
                            rate_next = rate_eff;
                    end
                    default: ;
                endcase
            end
        end
    end

    // a capture needs reader ready and both modem lines up
    assign cap_ok = try_cap && s1_item_reg.reader_ready && s1_item_reg.dtr
                    && s1_item_reg.rts;

    assign advance   = s1_valid_reg && (!cap_ok || cap_ready);
    assign cmd_ready = !s1_valid_reg || advance;
    assign cap_valid = s1_valid_reg && cap_ok;
    assign cap.data  = s1_item_reg.reader_data;
    assign cap.hex   = hex_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            rate_reg     <= '0;
            count_reg    <= '0;
            hex_reg      <= 1'b1;
        end
        else
        begin
            if (cmd_ready)
                s1_valid_reg <= cmd_valid;
            if (advance)
            begin
                rate_reg  <= rate_next;
                count_reg <= count_next;
                hex_reg   <= hex_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
            s1_item_reg <= cmd;
    end

endmodule

[sv/ptrc_ser.sv]
// ----------------------------------------------------------------------------
// ptrc_ser
// Holds one capture and sends it as one raw byte or hex digits, CR, LF.
// ----------------------------------------------------------------------------
module ptrc_ser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cap_valid,
    output logic                cap_ready,
    input  ptrc_pkg::capture_t  cap,
    output logic                res_valid,
    input  logic                res_ready,
    output ptrc_pkg::out_item_t res
);

    localparam logic [1:0] POS_HIGH = 2'd0;
    localparam logic [1:0] POS_LOW  = 2'd1;
    localparam logic [1:0] POS_CR   = 2'd2;
    localparam logic [1:0] POS_LF   = 2'd3;

    logic               busy_reg;
    logic               busy_next;
    logic [1:0]         pos_reg;
    logic [1:0]         pos_next;
    ptrc_pkg::capture_t cap_reg;
    logic               last;

    assign last      = !cap_reg.hex || (pos_reg == POS_LF);
    assign res_valid = busy_reg;
    assign cap_ready = !busy_reg || (res_ready && last);

    always_comb
    begin
        case (pos_reg)
            POS_HIGH: res.out_byte = cap_reg.hex ? ptrc_pkg::hex_digit(cap_reg.data[7:4])
                                                 : cap_reg.data;
            POS_LOW:  res.out_byte = ptrc_pkg::hex_digit(cap_reg.data[3:0]);
            POS_CR:   res.out_byte = ptrc_pkg::CHAR_CR;
            POS_LF:   res.out_byte = ptrc_pkg::CHAR_LF;
            default:  res.out_byte = ptrc_pkg::CHAR_LF;
        endcase
        res.reader_strobe = (pos_reg == POS_HIGH);
        res.last_in_run   = last;
    end

    always_comb
    begin
        busy_next = busy_reg;
        pos_next  = pos_reg;
        if (cap_valid && cap_ready)
        begin
            busy_next = 1'b1;
            pos_next  = POS_HIGH;
        end
        else if (res_valid && res_ready)
        begin
            if (last)
                busy_next = 1'b0;
            else
                pos_next = pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pos_reg  <= POS_HIGH;
        end
        else
        begin
            busy_reg <= busy_next;
            pos_reg  <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cap_valid && cap_ready)
            cap_reg <= cap;
    end

endmodule
